// ===== hw/rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// Used by ultrasonic_echo_ranger_unit; depends on nothing else.
`timescale 1ns / 1ps

package uer_pkg;

   localparam int DEFAULT_COUNT_BITS = 18;

   localparam int TRIG_W  = 16;
   localparam int TOUT_W  = 18;
   localparam int HOLD_W  = 16;
   localparam int DIST_W  = 10;
   localparam int STORE_W = 12;
   localparam int REM_W   = 14;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(24);
   localparam logic [TOUT_W-1:0] TOUT_RESET = TOUT_W'(131072);
   localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(20000);
   localparam logic [DIST_W-1:0] MAXD_RESET = DIST_W'(300);

   // distance = floor(172 * floor(ticks / 2) / 10000), tracked as quotient and remainder
   localparam logic [REM_W-1:0]   CM_STEP   = REM_W'(172);
   localparam logic [REM_W-1:0]   CM_DIV    = REM_W'(10000);
   localparam logic [STORE_W-1:0] STORE_MAX = {STORE_W{1'b1}};

   typedef enum logic [1:0] {
      REG_TRIGGER_TICKS = 2'd0,
      REG_ECHO_TIMEOUT  = 2'd1,
      REG_HOLDOFF_TICKS = 2'd2,
      REG_MAX_DISTANCE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic              trigger_level;
      logic              result_ready;
      logic [DIST_W-1:0] distance_cm;
   } result_type;

endpackage

// ===== hw/rtl/ultrasonic_echo_ranger_unit.sv =====
// Top level of the ultrasonic echo ranger: tick-driven trigger/echo sequencer with APB registers.
// Depends on uer_pkg.
`timescale 1ns / 1ps

// Each input transfer is one 0.5 us tick and yields exactly one result transfer. The block takes
// one tick in every clock cycle while req_stall is low, and registers its result. A two-entry
// output buffer (result register plus skid register) lets the next tick enter while a result
// waits, so req_stall rises only when both entries are full. The echo distance is built
// up during the echo phase by a running quotient and remainder (add 172, subtract 10000 on wrap),
// so no divider sits in the tick path. Registers sit at byte addresses 0, 4, 8 and 12: trigger
// ticks, echo timeout ticks, holdoff ticks and maximum distance in cm; write them between
// transfers. There is no clearing pass after reset.
module ultrasonic_echo_ranger_unit #(
   parameter int COUNT_BITS = uer_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic                                 req_echo_level,
   input  logic                                 req_take_result,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_trigger_level,
   output logic                                 rsp_result_ready,
   output logic [uer_pkg::DIST_W-1:0]           rsp_distance_cm,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [uer_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [uer_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [uer_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import uer_pkg::*;

   localparam int CMP_W = (COUNT_BITS > TOUT_W) ? COUNT_BITS : TOUT_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TRIG = 3'd1,
      PH_WAIT = 3'd2,
      PH_ECHO = 3'd3,
      PH_HOLD = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   logic [TRIG_W-1:0] trig_ticks_ff;
   logic [TOUT_W-1:0] tout_ticks_ff;
   logic [HOLD_W-1:0] hold_ticks_ff;
   logic [DIST_W-1:0] max_dist_ff;

   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   echo_prev_ff;
   logic [STORE_W-1:0]     store_ff, store_in;
   logic [STORE_W-1:0]     quot_ff, quot_in;
   logic [REM_W-1:0]       rem_ff, rem_in;

   result_type rsp_ff, skid_ff, result_in;
   logic       rsp_valid_ff, skid_valid_ff;

   logic                  req_xfer, rsp_xfer, csr_wr;
   reg_index_type         csr_idx;
   logic [COUNT_BITS-1:0] cnt_up;
   logic                  cnt_moved;
   logic [REM_W-1:0]      rem_sum;
   logic                  tout_hit;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = rsp_ff.trigger_level;
   assign rsp_result_ready  = rsp_ff.result_ready;
   assign rsp_distance_cm   = rsp_ff.distance_cm;

   // configuration port
   assign pready  = 1'b1;
   assign csr_idx = reg_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      case (csr_idx)
         REG_TRIGGER_TICKS: prdata = CSR_DATA_W'(trig_ticks_ff);
         REG_ECHO_TIMEOUT:  prdata = CSR_DATA_W'(tout_ticks_ff);
         REG_HOLDOFF_TICKS: prdata = CSR_DATA_W'(hold_ticks_ff);
         REG_MAX_DISTANCE:  prdata = CSR_DATA_W'(max_dist_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff <= TRIG_RESET;
         tout_ticks_ff <= TOUT_RESET;
         hold_ticks_ff <= HOLD_RESET;
         max_dist_ff   <= MAXD_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TRIGGER_TICKS: trig_ticks_ff <= pwdata[TRIG_W-1:0];
            REG_ECHO_TIMEOUT:  tout_ticks_ff <= pwdata[TOUT_W-1:0];
            REG_HOLDOFF_TICKS: hold_ticks_ff <= pwdata[HOLD_W-1:0];
            REG_MAX_DISTANCE:  max_dist_ff   <= pwdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // tick sequencer
   assign cnt_up    = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
   assign cnt_moved = (cnt_ff != CNT_MAX);
   assign rem_sum   = rem_ff + CM_STEP;
   assign tout_hit  = (CMP_W'(cnt_up) >= CMP_W'(tout_ticks_ff)) || (cnt_up == CNT_MAX);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      store_in = store_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (req_take_result) begin
         phase_in = PH_IDLE;
      end
      if (req_start_req) begin
         phase_in = PH_TRIG;
         cnt_in   = '0;
      end else begin
         case (phase_in)
            PH_TRIG: begin
               cnt_in = cnt_up;
               if (CMP_W'(cnt_up) >= CMP_W'(trig_ticks_ff)) begin
                  phase_in = PH_WAIT;
                  cnt_in   = '0;
               end
            end
            PH_WAIT: begin
               if (req_echo_level && !echo_prev_ff) begin
                  phase_in = PH_ECHO;
                  cnt_in   = COUNT_BITS'(1);
                  quot_in  = '0;
                  rem_in   = '0;
               end else begin
                  cnt_in = cnt_up;
                  if (tout_hit) begin
                     phase_in = PH_HOLD;
                     cnt_in   = '0;
                  end
               end
            end
            PH_ECHO: begin
               if (!req_echo_level && echo_prev_ff) begin
                  store_in = quot_ff;
                  phase_in = PH_DONE;
               end else begin
                  cnt_in = cnt_up;
                  // half count advances on every even count
                  if (cnt_moved && !cnt_up[0]) begin
                     if (rem_sum >= CM_DIV) begin
                        rem_in = rem_sum - CM_DIV;
                        if (quot_ff != STORE_MAX) begin
                           quot_in = quot_ff + 1'b1;
                        end
                     end else begin
                        rem_in = rem_sum;
                     end
                  end
                  if (tout_hit) begin
                     phase_in = PH_HOLD;
                     cnt_in   = '0;
                  end
               end
            end
            PH_HOLD: begin
               cnt_in = cnt_up;
               if (CMP_W'(cnt_up) >= CMP_W'(hold_ticks_ff)) begin
                  store_in = STORE_W'(max_dist_ff);
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
      result_in.trigger_level = (phase_in == PH_TRIG);
      result_in.result_ready  = (phase_in == PH_DONE);
      result_in.distance_cm   = (store_in > STORE_W'(max_dist_ff)) ? max_dist_ff
                                                                  : store_in[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         echo_prev_ff <= 1'b0;
         store_ff     <= '0;
      end else if (req_xfer) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         echo_prev_ff <= req_echo_level;
         store_ff     <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   // two-entry output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_ff       <= result_in;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in front");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.trigger_level && rsp_ff.result_ready))
      else $error("trigger and ready flagged together");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ECHO) |-> (rem_ff < CM_DIV))
      else $error("distance remainder out of range");

   a_echo_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ECHO) |-> (cnt_ff != '0))
      else $error("echo phase with zero count");

   a_start_trig: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_start_req) |=> (phase_ff == PH_TRIG))
      else $error("start did not enter trigger phase");

endmodule

// ===== sim/ultrasonic_echo_ranger_unit_tb.sv =====
// Testbench for ultrasonic_echo_ranger_unit: sends one echo tick per transfer, predicts trigger,
// ready and distance for every tick and compares each result transfer against that prediction.
// Depends on uer_pkg and the ranger RTL; needs no other files.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit_tb;
   import uer_pkg::*;

   localparam int CNT_W = DEFAULT_COUNT_BITS;
   localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIGGER   = 3'd1,
      PH_WAIT_ECHO = 3'd2,
      PH_ECHO      = 3'd3,
      PH_HOLDOFF   = 3'd4,
      PH_RESULT    = 3'd5
   } ranger_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_start_req = 1'b0;
   logic                  req_echo_level = 1'b0;
   logic                  req_take_result = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_trigger_level;
   logic                  rsp_result_ready;
   logic [DIST_W-1:0]     rsp_distance_cm;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ultrasonic_echo_ranger_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_req(req_start_req),
      .req_echo_level(req_echo_level),
      .req_take_result(req_take_result),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_trigger_level(rsp_trigger_level),
      .rsp_result_ready(rsp_result_ready),
      .rsp_distance_cm(rsp_distance_cm),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [TRIG_W-1:0]  cfg_trigger;
   logic [TOUT_W-1:0]  cfg_timeout;
   logic [HOLD_W-1:0]  cfg_holdoff;
   logic [DIST_W-1:0]  cfg_max_cm;
   ranger_phase_type   phase_now;
   logic [CNT_W-1:0]   tick_count;
   logic               echo_before;
   logic [STORE_W-1:0] distance_held;

   result_type ranger_outputs_due[$];

   int  mismatches = 0;
   int  ticks_sent = 0;
   int  outputs_checked = 0;
   int  ready_ticks = 0;
   int  settings_used = 0;
   logic send_quiet = 1'b0;
   logic stall_quiet = 1'b0;
   int  stall_left = 0;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: mismatch: %s", $time, what);
   endtask

   function automatic void bump_count();
      if (tick_count != CNT_FULL)
         tick_count = tick_count + 1'b1;
   endfunction

   function automatic void end_wait_on_timeout();
      bump_count();
      if (tick_count >= cfg_timeout || tick_count == CNT_FULL) begin
         phase_now = PH_HOLDOFF;
         tick_count = '0;
      end
   endfunction

   function automatic result_type advance_ranger(input logic start, input logic echo,
                                                 input logic take);
      logic [31:0]        cm;
      logic [STORE_W-1:0] shown;
      result_type         res;
      if (take)
         phase_now = PH_IDLE;
      if (start) begin
         phase_now = PH_TRIGGER;
         tick_count = '0;
      end else begin
         case (phase_now)
            PH_TRIGGER: begin
               bump_count();
               if (tick_count >= cfg_trigger) begin
                  phase_now = PH_WAIT_ECHO;
                  tick_count = '0;
               end
            end
            PH_WAIT_ECHO: begin
               if (echo && !echo_before) begin
                  phase_now = PH_ECHO;
                  tick_count = CNT_W'(1);
               end else begin
                  end_wait_on_timeout();
               end
            end
            PH_ECHO: begin
               if (!echo && echo_before) begin
                  cm = (32'd172 * 32'(tick_count >> 1)) / 32'd10000;
                  distance_held = (cm > 32'd4095) ? STORE_MAX : cm[STORE_W-1:0];
                  phase_now = PH_RESULT;
               end else begin
                  end_wait_on_timeout();
               end
            end
            PH_HOLDOFF: begin
               bump_count();
               if (tick_count >= cfg_holdoff) begin
                  distance_held = STORE_W'(cfg_max_cm);
                  phase_now = PH_RESULT;
               end
            end
            default: begin
            end
         endcase
      end
      echo_before = echo;
      shown = (distance_held > STORE_W'(cfg_max_cm)) ? STORE_W'(cfg_max_cm) : distance_held;
      res.trigger_level = (phase_now == PH_TRIGGER);
      res.result_ready = (phase_now == PH_RESULT);
      res.distance_cm = shown[DIST_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ranger_outputs_due.size() == 0) begin
            report_mismatch("result transfer with no tick outstanding");
         end else begin
            due = ranger_outputs_due.pop_front();
            if (rsp_trigger_level !== due.trigger_level)
               report_mismatch($sformatf("result %0d: trigger_level %b, want %b",
                  outputs_checked, rsp_trigger_level, due.trigger_level));
            if (rsp_result_ready !== due.result_ready)
               report_mismatch($sformatf("result %0d: result_ready %b, want %b",
                  outputs_checked, rsp_result_ready, due.result_ready));
            if (rsp_distance_cm !== due.distance_cm)
               report_mismatch($sformatf("result %0d: distance_cm %0d, want %0d",
                  outputs_checked, rsp_distance_cm, due.distance_cm));
            if (due.result_ready)
               ready_ticks++;
            outputs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      int pick;
      if (stall_quiet) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(1, 8);
         end else if (pick < 8) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 3);
         end else if (pick == 8) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 30);
         end else begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(60, 200);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_quiet || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_tick(input logic start, input logic echo, input logic take);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_echo_level <= echo;
      req_take_result <= take;
      do @(posedge clock); while (req_stall);
      ranger_outputs_due.push_back(advance_ranger(start, echo, take));
      ticks_sent++;
   endtask

   task automatic send_run(input logic start, input logic echo, input logic take,
                           input int count);
      repeat (count) send_tick(start, echo, take);
   endtask

   task automatic drain_outputs();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (ranger_outputs_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (ranger_outputs_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", ranger_outputs_due.size()));
         ranger_outputs_due.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_check(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      case (idx)
         REG_TRIGGER_TICKS: want = CSR_DATA_W'(cfg_trigger);
         REG_ECHO_TIMEOUT:  want = CSR_DATA_W'(cfg_timeout);
         REG_HOLDOFF_TICKS: want = CSR_DATA_W'(cfg_holdoff);
         default:           want = CSR_DATA_W'(cfg_max_cm);
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         report_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(), prdata, want));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_TRIGGER_TICKS: cfg_trigger = value[TRIG_W-1:0];
         REG_ECHO_TIMEOUT:  cfg_timeout = value[TOUT_W-1:0];
         REG_HOLDOFF_TICKS: cfg_holdoff = value[HOLD_W-1:0];
         default:           cfg_max_cm = value[DIST_W-1:0];
      endcase
      @(posedge clock);
      csr_check(idx);
   endtask

   task automatic apply_settings(input logic [31:0] trig, input logic [31:0] tout,
                                 input logic [31:0] hold, input logic [31:0] max_cm);
      drain_outputs();
      csr_write(REG_TRIGGER_TICKS, trig);
      csr_write(REG_ECHO_TIMEOUT, tout);
      csr_write(REG_HOLDOFF_TICKS, hold);
      csr_write(REG_MAX_DISTANCE, max_cm);
      settings_used++;
   endtask

   task automatic test_reset_registers();
      for (int i = 0; i < 4; i++)
         csr_check(reg_index_type'(i));
   endtask

   task automatic test_directed_sequences();
      apply_settings(2, 5, 2, 1023);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'b0);
      send_run(1'b0, 1'b0, 1'b0, 2);
      send_run(1'b0, 1'b1, 1'b0, 2);
      send_run(1'b0, 1'b0, 1'b0, 2);
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b1, 1'b1, 1'b0);
      send_run(1'b0, 1'b1, 1'b0, 7);
      send_run(1'b0, 1'b0, 1'b0, 2);
      send_tick(1'b0, 1'b0, 1'b1);
      apply_settings(0, 0, 0, 0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      send_run(1'b0, 1'b1, 1'b0, 2);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b1);
      send_run(1'b0, 1'b0, 1'b0, 3);
      send_tick(1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_extreme_timing();
      send_quiet = 1'b1;
      stall_quiet = 1'b1;
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick(1'b1, 1'b0, 1'b0);
      send_run(1'b0, 1'b1, 1'b0, 30);
      send_tick(1'b0, 1'b0, 1'b1);
      apply_settings(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023);
      send_tick(1'b1, 1'b0, 1'b0);
      send_run(1'b0, 1'b0, 1'b0, 2);
      send_run(1'b0, 1'b1, 1'b0, 120);
      send_run(1'b0, 1'b0, 1'b0, 2);
      send_tick(1'b0, 1'b0, 1'b1);
      send_quiet = 1'b0;
      stall_quiet = 1'b0;
   endtask

   task automatic run_measurement();
      int lead;
      int width;
      lead = ($urandom_range(0, 4) == 0) ? int'(cfg_timeout) + 2 : $urandom_range(0, 6);
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(110, 340) : $urandom_range(1, 20);
      send_tick(1'b1, 1'b0, 1'($urandom_range(0, 1)));
      repeat (cfg_trigger) send_tick(1'b0, $urandom_range(0, 9) == 0, 1'b0);
      send_run(1'b0, 1'b0, 1'b0, lead);
      repeat (width) send_tick(1'b0, 1'b1, $urandom_range(0, 149) == 0);
      send_run(1'b0, 1'b0, 1'b0, $urandom_range(1, int'(cfg_holdoff) + 3));
      if ($urandom_range(0, 3) != 0)
         send_tick($urandom_range(0, 4) == 0, 1'b0, 1'b1);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 30))
         send_tick($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7) == 0);
   endtask

   task automatic test_random_ranging();
      logic [31:0] trig;
      logic [31:0] tout;
      logic [31:0] hold;
      logic [31:0] max_cm;
      int          goal;
      for (int p = 0; p < 5; p++) begin
         trig = (p == 1) ? 0 : $urandom_range(1, 6);
         tout = (p == 2) ? $urandom_range(0, 12) : $urandom_range(130, 320);
         hold = $urandom_range(0, 8);
         case (p)
            0:       max_cm = 1023;
            1:       max_cm = 1;
            2:       max_cm = 0;
            3:       max_cm = 2;
            default: max_cm = $urandom_range(0, 1023);
         endcase
         apply_settings(trig, tout, hold, max_cm);
         goal = ticks_sent + 170;
         while (ticks_sent < goal) begin
            if ($urandom_range(0, 9) < 7)
               run_measurement();
            else
               send_noise();
            if ($urandom_range(0, 11) == 0)
               drain_outputs();
            send_quiet = ($urandom_range(0, 3) == 0);
         end
         send_quiet = 1'b0;
      end
   endtask

   initial begin
      cfg_trigger = TRIG_RESET;
      cfg_timeout = TOUT_RESET;
      cfg_holdoff = HOLD_RESET;
      cfg_max_cm = MAXD_RESET;
      phase_now = PH_IDLE;
      tick_count = '0;
      echo_before = 1'b0;
      distance_held = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_registers();
      test_directed_sequences();
      test_extreme_timing();
      test_random_ranging();
      drain_outputs();
      repeat (10) @(posedge clock);
      $display("covered %0d ticks under %0d register settings, %0d of them with a distance ready",
               ticks_sent, settings_used, ready_ticks);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("run timed out with %0d results outstanding", ranger_outputs_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger_unit.sv
sim/ultrasonic_echo_ranger_unit_tb.sv
